// ===== rtl/bessel_first_kind_simpson_top_macros.svh =====
// Assertion macros for the Bessel integral block.
// Used by the top level only; depends on nothing.
`ifndef BESSEL_FIRST_KIND_SIMPSON_TOP_MACROS_SVH
`define BESSEL_FIRST_KIND_SIMPSON_TOP_MACROS_SVH

// same-cycle implication
`define BFKS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFKS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bfks_pkg.sv =====
// Shared types and constants of the Bessel integral block.
// No dependencies.
package bfks_pkg;

   localparam int X_W     = 24;
   localparam int Y_W     = 18;
   localparam int ORDER_W = 4;

   localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
   localparam logic [30:0] PI_HALF_Q30  = 31'd1686629713;
   localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [16:0] SAT_MAX      = 17'd65536;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;
   localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
   localparam int COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

   typedef struct packed {
      logic first;
      logic last;
      logic odd;
   } tag_type;

   typedef struct packed {
      logic [31:0] nph;
      logic [23:0] xmag;
      logic        xneg;
      tag_type     tag;
   } node_type;

endpackage

// ===== rtl/bfks_stream_if.sv =====
// Valid/ready channels for arguments and results.
// Depends on bfks_pkg.
interface bfks_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [bfks_pkg::X_W-1:0] arg_x;
   modport source (output valid, output arg_x, input ready);
   modport sink (input valid, input arg_x, output ready);
endinterface

interface bfks_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [bfks_pkg::Y_W-1:0] bessel_value;
   modport source (output valid, output bessel_value, input ready);
   modport sink (input valid, input bessel_value, output ready);
endinterface

// ===== rtl/bfks_cdiv.sv =====
// Pipelined division by a constant: reciprocal multiply, then one correction.
// Two register stages. No dependencies.
module bfks_cdiv #(
   parameter int K  = 3,
   parameter int AW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [AW-1:0] a,
   input  logic [SW-1:0] side,
   output logic          out_valid,
   output logic [AW-1:0] q,
   output logic [SW-1:0] side_out
);
   localparam int          KW    = $clog2(K + 1);
   localparam logic [63:0] M64   = (64'd1 << AW) / K;
   localparam logic [AW-1:0] MULT = M64[AW-1:0];
   localparam logic [KW-1:0] KV  = KW'(K);

   logic [2*AW-1:0]  prod_in, prod_ff;
   logic [AW-1:0]    a_ff, qe, rem, q_in, q_ff;
   logic [AW+KW-1:0] back;
   logic [SW-1:0]    side_ff, side2_ff;
   logic             v_ff, v2_ff;

   assign prod_in = {{AW{1'b0}}, a} * {{AW{1'b0}}, MULT};
   assign qe      = prod_ff[2*AW-1:AW];
   assign back    = {{KW{1'b0}}, qe} * {{AW{1'b0}}, KV};
   assign rem     = a_ff - back[AW-1:0];
   assign q_in    = (rem >= AW'(K)) ? qe + 1'b1 : qe;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v_ff  <= in_valid;
         v2_ff <= v_ff;
      end
      prod_ff  <= prod_in;
      a_ff     <= a;
      side_ff  <= side;
      q_ff     <= q_in;
      side2_ff <= side_ff;
   end

   assign out_valid = v2_ff;
   assign q         = q_ff;
   assign side_out  = side2_ff;
endmodule

// ===== rtl/bfks_horner.sv =====
// One Horner step acc' = 1 - floor(floor(x2*acc/2^30)/K), three register stages.
// Depends on bfks_pkg and bfks_cdiv; x2 rides in the top 32 bits of side.
module bfks_horner #(
   parameter int K  = 2,
   parameter int SW = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [30:0]        acc,
   input  logic [SW-1:0]      side,
   output logic               out_valid,
   output logic signed [31:0] acc_out,
   output logic [SW-1:0]      side_out
);
   import bfks_pkg::*;

   logic [31:0]   x2, p_in, p_ff, q;
   logic [62:0]   prod;
   logic [SW-1:0] side_ff;
   logic          v_ff;

   assign x2   = side[SW-1 -: 32];
   assign prod = {31'd0, x2} * {32'd0, acc};
   assign p_in = prod[61:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
      p_ff    <= p_in;
      side_ff <= side;
   end

   bfks_cdiv #(.K(K), .AW(32), .SW(SW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff),
      .a         (p_ff),
      .side      (side_ff),
      .out_valid (out_valid),
      .q         (q),
      .side_out  (side_out)
   );

   assign acc_out = $signed(Q30_ONE - q);
endmodule

// ===== rtl/bfks_cospipe.sv =====
// Pipelined cosine of a 32-bit phase, Q30 result.
// Depends on bfks_pkg and bfks_horner.
module bfks_cospipe #(
   parameter int SW = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        phase,
   input  logic [SW-1:0]      side,
   output logic               out_valid,
   output logic signed [31:0] cv,
   output logic [SW-1:0]      side_out
);
   import bfks_pkg::*;

   localparam int CSW = SW + 34;
   localparam int SSW = 63;

   logic [60:0]   xr_prod;
   logic [30:0]   xr_in, xr0_ff, xr1_ff;
   logic [61:0]   x2_prod, sf_prod;
   logic [31:0]   x2_in, x2_ff, sf_in, sf_ff, sd1_ff, sd2_ff;
   logic [1:0]    q0_ff, q1_ff, quad;
   logic [SW-1:0] side0_ff, side1_ff, side_o_ff;
   logic          v0_ff, v1_ff, sf_v_ff, sd1_v_ff, sd2_v_ff, v_o_ff;

   logic signed [31:0] cos_acc [COS_STEPS+1];
   logic [CSW-1:0]     cos_side [COS_STEPS+1];
   logic               cos_v [COS_STEPS+1];
   logic signed [31:0] sin_acc [SIN_STEPS+1];
   logic [SSW-1:0]     sin_side [SIN_STEPS+1];
   logic               sin_v [SIN_STEPS+1];
   logic signed [31:0] c_val, s_val, cv_in, cv_ff;

   assign xr_prod = {31'd0, phase[29:0]} * {30'd0, PI_HALF_Q30};
   assign xr_in   = xr_prod[60:30];
   assign x2_prod = {31'd0, xr0_ff} * {31'd0, xr0_ff};
   assign x2_in   = x2_prod[61:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
      xr0_ff   <= xr_in;
      q0_ff    <= phase[31:30];
      side0_ff <= side;
      x2_ff    <= x2_in;
      xr1_ff   <= xr0_ff;
      q1_ff    <= q0_ff;
      side1_ff <= side0_ff;
   end

   assign cos_acc[0]  = $signed(Q30_ONE);
   assign cos_side[0] = {x2_ff, q1_ff, side1_ff};
   assign cos_v[0]    = v1_ff;
   assign sin_acc[0]  = $signed(Q30_ONE);
   assign sin_side[0] = {x2_ff, xr1_ff};
   assign sin_v[0]    = v1_ff;

   for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
      bfks_horner #(.K(COS_DIV[g]), .SW(CSW)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cos_v[g]),
         .acc       (cos_acc[g][30:0]),
         .side      (cos_side[g]),
         .out_valid (cos_v[g+1]),
         .acc_out   (cos_acc[g+1]),
         .side_out  (cos_side[g+1])
      );
   end

   for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
      bfks_horner #(.K(SIN_DIV[g]), .SW(SSW)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sin_v[g]),
         .acc       (sin_acc[g][30:0]),
         .side      (sin_side[g]),
         .out_valid (sin_v[g+1]),
         .acc_out   (sin_acc[g+1]),
         .side_out  (sin_side[g+1])
      );
   end

   assign sf_prod = {31'd0, sin_side[SIN_STEPS][30:0]} * {31'd0, sin_acc[SIN_STEPS][30:0]};
   assign sf_in   = sf_prod[61:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_v_ff  <= 1'b0;
         sd1_v_ff <= 1'b0;
         sd2_v_ff <= 1'b0;
         v_o_ff   <= 1'b0;
      end else begin
         sf_v_ff  <= sin_v[SIN_STEPS];
         sd1_v_ff <= sf_v_ff;
         sd2_v_ff <= sd1_v_ff;
         v_o_ff   <= cos_v[COS_STEPS] & sd2_v_ff;
      end
      sf_ff     <= sf_in;
      sd1_ff    <= sf_ff;
      sd2_ff    <= sd1_ff;
      cv_ff     <= cv_in;
      side_o_ff <= cos_side[COS_STEPS][SW-1:0];
   end

   assign quad  = cos_side[COS_STEPS][SW+1:SW];
   assign c_val = cos_acc[COS_STEPS];
   assign s_val = $signed(sd2_ff);

   always_comb begin
      unique case (quad)
         QUAD_0:  cv_in = c_val;
         QUAD_1:  cv_in = -s_val;
         QUAD_2:  cv_in = -c_val;
         QUAD_3:  cv_in = s_val;
         default: cv_in = c_val;
      endcase
   end

   assign out_valid = v_o_ff;
   assign cv        = cv_ff;
   assign side_out  = side_o_ff;
endmodule

// ===== rtl/bessel_first_kind_simpson_top.sv =====
// J_n(x) by Simpson's rule on Bessel's integral, one quadrature node a cycle.
// An item occupies the node sequencer until its last node, where the next argument may already be taken.
// Its result passes two cosine pipelines in series, then the Simpson sum, divider and result buffer.
// Up to 32 results are buffered; reset (synchronous) clears order, sequencer and buffer.
// Depends on bfks_pkg, bfks_stream_if, bfks_cospipe, bfks_cdiv and the macros header.
`include "bessel_first_kind_simpson_top_macros.svh"

module bessel_first_kind_simpson_top #(
   parameter int SIMPSON_INTERVALS = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   bfks_req_if.sink                      req_ch,
   bfks_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bfks_pkg::ORDER_W-1:0]  csr_wr_data
);
   import bfks_pkg::*;

   localparam int N     = SIMPSON_INTERVALS;
   localparam int IW    = $clog2(N + 1);
   localparam int RW    = $clog2(N) + 1;
   localparam int SUM_W = $clog2(3 * N) + 32;
   localparam int FAW   = SUM_W - 14;
   localparam int DEPTH = 32;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = PW + 1;
   localparam int NORD  = 2 ** ORDER_W;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(64'(3 * N) << 13);

   // phase steps per order: floor(n*2^31/N) and remainder
   logic [31:0]   nq_tab [NORD];
   logic [RW-1:0] nr_tab [NORD];
   for (genvar g = 0; g < NORD; g++) begin : g_ord
      localparam logic [63:0] NUM = 64'(g) << 31;
      localparam logic [63:0] QG  = NUM / N;
      localparam logic [63:0] RG  = NUM % N;
      assign nq_tab[g] = QG[31:0];
      assign nr_tab[g] = RG[RW-1:0];
   end

   logic [ORDER_W-1:0] order_ff;
   logic               busy_ff, busy_in, last_node, req_xfer, rsp_xfer;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [31:0]        tph_ff, tph_in, nph_ff, nph_in, nq_ff, nq_in;
   logic [RW-1:0]      trem_ff, trem_in, nrem_ff, nrem_in, nr_ff, nr_in, tsum, nsum;
   logic [23:0]        xmag_ff, xmag_in;
   logic               xneg_ff, xneg_in, tcar, ncar;
   logic [CW-1:0]      outst_ff, outst_in;

   assign last_node = (idx_ff == IW'(N));
   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign rsp_xfer  = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (!busy_ff || last_node) && (outst_ff < CW'(DEPTH));

   assign tsum = trem_ff + nr_tab[1];
   assign tcar = (tsum >= RW'(N));
   assign nsum = nrem_ff + nr_ff;
   assign ncar = (nsum >= RW'(N));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      tph_in  = tph_ff;
      trem_in = trem_ff;
      nph_in  = nph_ff;
      nrem_in = nrem_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      xmag_in = xmag_ff;
      xneg_in = xneg_ff;
      priority if (req_xfer) begin
         busy_in = 1'b1;
         idx_in  = '0;
         tph_in  = '0;
         trem_in = '0;
         nph_in  = '0;
         nrem_in = '0;
         nq_in   = nq_tab[order_ff];
         nr_in   = nr_tab[order_ff];
         xneg_in = req_ch.arg_x[X_W-1];
         xmag_in = req_ch.arg_x[X_W-1] ? (~req_ch.arg_x) + 1'b1 : req_ch.arg_x;
      end else if (busy_ff && last_node) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         idx_in  = idx_ff + 1'b1;
         tph_in  = tph_ff + nq_tab[1] + {31'd0, tcar};
         trem_in = tcar ? tsum - RW'(N) : tsum;
         nph_in  = nph_ff + nq_ff + {31'd0, ncar};
         nrem_in = ncar ? nsum - RW'(N) : nsum;
      end
   end

   assign outst_in = outst_ff + {{(CW-1){1'b0}}, req_xfer} - {{(CW-1){1'b0}}, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         busy_ff  <= 1'b0;
         outst_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         busy_ff  <= busy_in;
         outst_ff <= outst_in;
      end
      idx_ff  <= idx_in;
      tph_ff  <= tph_in;
      trem_ff <= trem_in;
      nph_ff  <= nph_in;
      nrem_ff <= nrem_in;
      nq_ff   <= nq_in;
      nr_ff   <= nr_in;
      xmag_ff <= xmag_in;
      xneg_ff <= xneg_in;
   end

   // node issue
   node_type node_is;
   assign node_is.nph       = nph_ff;
   assign node_is.xmag      = xmag_ff;
   assign node_is.xneg      = xneg_ff;
   assign node_is.tag.first = (idx_ff == '0);
   assign node_is.tag.last  = last_node;
   assign node_is.tag.odd   = idx_ff[0];

   logic                       s_v;
   logic signed [31:0]         s_val;
   logic [$bits(node_type)-1:0] s_side;
   node_type                   s_node;

   bfks_cospipe #(.SW($bits(node_type))) u_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (busy_ff),
      .phase     (tph_ff - QUARTER_TURN),
      .side      (node_is),
      .out_valid (s_v),
      .cv        (s_val),
      .side_out  (s_side)
   );
   assign s_node = node_type'(s_side);

   // x*sin t into phase units
   logic        sneg, m1_v_ff, m2_v_ff, m3_v_ff, flip_in, m1_flip_ff, m2_flip_ff;
   logic [30:0] smag;
   logic [54:0] rad_prod;
   logic [31:0] rad_in, rad_ff, du_in, du_ff, ph_in, ph_ff;
   logic [61:0] du_prod;
   node_type    m1_node_ff, m2_node_ff;
   tag_type     m3_tag_ff;

   assign sneg     = s_val[31];
   assign smag     = sneg ? 31'(-s_val) : s_val[30:0];
   assign rad_prod = {31'd0, s_node.xmag} * {24'd0, smag};
   assign rad_in   = rad_prod[53:22];
   assign flip_in  = s_node.xneg != sneg;
   assign du_prod  = {30'd0, rad_ff} * {32'd0, TURN_PER_RAD};
   assign du_in    = du_prod[55:24];
   assign ph_in    = m2_flip_ff ? m2_node_ff.nph + du_ff : m2_node_ff.nph - du_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= s_v;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
      rad_ff     <= rad_in;
      m1_node_ff <= s_node;
      m1_flip_ff <= flip_in;
      du_ff      <= du_in;
      m2_node_ff <= m1_node_ff;
      m2_flip_ff <= m1_flip_ff;
      ph_ff      <= ph_in;
      m3_tag_ff  <= m2_node_ff.tag;
   end

   logic               c_v;
   logic signed [31:0] c_val;
   logic [2:0]         c_side;
   tag_type            c_tag;

   bfks_cospipe #(.SW($bits(tag_type))) u_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_v_ff),
      .phase     (ph_ff),
      .side      (m3_tag_ff),
      .out_valid (c_v),
      .cv        (c_val),
      .side_out  (c_side)
   );
   assign c_tag = tag_type'(c_side);

   // Simpson weighting and sum
   logic signed [SUM_W-1:0] ext, wcv, sum_in, sum_ff, tot_ff;
   logic                    tot_v_ff, tot_v_in;

   assign ext = {{(SUM_W-32){c_val[31]}}, c_val};
   always_comb begin
      priority if (c_tag.first || c_tag.last) begin
         wcv = ext;
      end else if (c_tag.odd) begin
         wcv = ext <<< 2;
      end else begin
         wcv = ext <<< 1;
      end
   end
   assign sum_in   = c_tag.first ? wcv : sum_ff + wcv;
   assign tot_v_in = c_v && c_tag.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_v_ff <= 1'b0;
      end else begin
         tot_v_ff <= tot_v_in;
      end
      if (c_v) begin
         sum_ff <= sum_in;
      end
      tot_ff <= sum_in;
   end

   // divide by 3N*2^14, round half away, saturate
   logic             rneg, fa_v_ff, fd_v, fin_v_ff;
   logic [SUM_W-1:0] mag, rsum;
   logic [FAW-1:0]   fa_in, fa_ff, fq;
   logic             fa_neg_ff, fd_neg;
   logic [16:0]      sat;
   logic [Y_W-1:0]   fin_val_in, fin_val_ff;

   assign rneg  = tot_ff[SUM_W-1];
   assign mag   = rneg ? -tot_ff : tot_ff;
   assign rsum  = mag + HALF;
   assign fa_in = rsum[SUM_W-1:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_v_ff <= 1'b0;
      end else begin
         fa_v_ff <= tot_v_ff;
      end
      fa_ff     <= fa_in;
      fa_neg_ff <= rneg;
   end

   bfks_cdiv #(.K(3 * N), .AW(FAW), .SW(1)) u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fa_v_ff),
      .a         (fa_ff),
      .side      (fa_neg_ff),
      .out_valid (fd_v),
      .q         (fq),
      .side_out  (fd_neg)
   );

   assign sat        = (fq > FAW'(SAT_MAX)) ? SAT_MAX : fq[16:0];
   assign fin_val_in = fd_neg ? -{1'b0, sat} : {1'b0, sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else begin
         fin_v_ff <= fd_v;
      end
      fin_val_ff <= fin_val_in;
   end

   // result buffer
   logic [Y_W-1:0] fifo_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + {{(CW-1){1'b0}}, fin_v_ff} - {{(CW-1){1'b0}}, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (fin_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (fin_v_ff) begin
         fifo_ff[wr_ptr_ff] <= fin_val_ff;
      end
   end

   assign rsp_ch.valid        = (cnt_ff != '0);
   assign rsp_ch.bessel_value = fifo_ff[rd_ptr_ff];

   `BFKS_ASSERT_IMP(a_no_overlap, clock, reset, req_xfer && busy_ff, last_node, "transfer mid item")
   `BFKS_ASSERT_IMP(a_buf_room, clock, reset, fin_v_ff, (cnt_ff != CW'(DEPTH)) || rsp_xfer, "result buffer overrun")
   `BFKS_ASSERT_NXT(a_credit, clock, reset, rsp_xfer && !req_xfer, outst_ff == $past(outst_ff) - 1'b1, "credit count slip")
endmodule

// ===== test/tb_bessel_first_kind_simpson_top.sv =====
// Self-checking bench for bessel_first_kind_simpson_top: random and directed arguments
// over several orders, results checked against a bit-exact Simpson-rule predictor.
// Depends on bfks_pkg, bfks_stream_if and the block itself.
`timescale 1ns / 1ps

module tb_bessel_first_kind_simpson_top;
   import bfks_pkg::*;

   localparam int       NODES_N   = 100;
   localparam int       LIMIT     = 1000000;
   localparam int       PER_PHASE = 145;
   localparam int       SETTLE    = NODES_N + 60;
   localparam bit [4:0] ORDER_LIST [10] = '{0, 15, 1, 7, 2, 14, 3, 9, 5, 12};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ORDER_W-1:0] csr_wr_data;

   bfks_req_if req_ch ();
   bfks_rsp_if rsp_ch ();

   bessel_first_kind_simpson_top #(.SIMPSON_INTERVALS(NODES_N)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic signed [X_W-1:0] pending_args [$];
   logic signed [Y_W-1:0] expected_values [$];
   logic [ORDER_W-1:0]    model_order;
   int errors = 0;
   int sent = 0;
   int received = 0;
   int cycles = 0;
   bit hold_done = 0;
   int hold_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cos of a 32-bit phase, Q30
   function automatic longint cos_of_phase(bit [31:0] ph);
      longint sin_div [5];
      longint cos_div [6];
      longint xr, x2, acc, s, c;
      bit [63:0] r;
      sin_div = '{110, 72, 42, 20, 6};
      cos_div = '{132, 90, 56, 30, 12, 2};
      r  = {34'd0, ph[29:0]};
      xr = longint'((r * 64'd1686629713) >> 30);
      x2 = longint'((64'(xr) * 64'(xr)) >> 30);
      acc = 64'sd1 <<< 30;
      for (int k = 0; k < 5; k++) acc = (64'sd1 <<< 30) - ((x2 * acc) >>> 30) / sin_div[k];
      s = (xr * acc) >>> 30;
      acc = 64'sd1 <<< 30;
      for (int k = 0; k < 6; k++) acc = (64'sd1 <<< 30) - ((x2 * acc) >>> 30) / cos_div[k];
      c = acc;
      case (ph[31:30])
         QUAD_0: return c;
         QUAD_1: return -s;
         QUAD_2: return -c;
         default: return s;
      endcase
   endfunction

   function automatic logic signed [Y_W-1:0] bessel_of(logic signed [X_W-1:0] x,
                                                      logic [ORDER_W-1:0] n);
      bit xneg, sneg, rneg;
      bit [63:0] xmag, smag, rad24, mag, d, qv;
      bit [31:0] tph, nph, du, ph;
      longint s, sum, w;
      xneg = x[X_W-1];
      xmag = xneg ? 64'(-longint'(x)) : 64'(x);
      sum = 0;
      for (int i = 0; i <= NODES_N; i++) begin
         tph = 32'((64'(i) << 31) / NODES_N);
         nph = 32'((64'(n) * 64'(i) << 31) / NODES_N);
         s = cos_of_phase(tph - QUARTER_TURN);
         sneg = s < 0;
         smag = sneg ? 64'(-s) : 64'(s);
         rad24 = (xmag * smag) >> 22;
         du = 32'((rad24 * 64'd683565276) >> 24);
         ph = (xneg != sneg) ? nph + du : nph - du;
         w = (i == 0 || i == NODES_N) ? 1 : ((i % 2) ? 4 : 2);
         sum += w * cos_of_phase(ph);
      end
      d = 3 * NODES_N * (64'd1 << 14);
      rneg = sum < 0;
      mag = rneg ? 64'(-sum) : 64'(sum);
      qv = (mag + d / 2) / d;
      if (qv > 65536) qv = 65536;
      return rneg ? -Y_W'(qv) : Y_W'(qv);
   endfunction

   function automatic logic signed [X_W-1:0] random_arg();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return X_W'($urandom);
      if (sel < 8) return X_W'($urandom_range(0, 20 * 65536)) * ($urandom_range(0, 1) ? 1 : -1);
      case ($urandom_range(0, 3))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return X_W'($urandom_range(0, 15)) - 8;
         default: return X_W'($urandom_range(0, 255)) <<< 16;
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.arg_x <= '0;
      end else begin
         bit busy;
         busy = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_values.push_back(bessel_of(req_ch.arg_x, model_order));
            sent++;
            busy = 0;
         end
         if (!busy) begin
            bit quiet;
            quiet = (sent > 400 && sent < 650);
            if (pending_args.size() > 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
               req_ch.valid <= 1'b1;
               req_ch.arg_x <= pending_args.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            received++;
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected result, actual %0d", $time, rsp_ch.bessel_value);
               errors++;
            end else begin
               logic signed [Y_W-1:0] want;
               want = expected_values.pop_front();
               if (want !== rsp_ch.bessel_value) begin
                  $display("%0t: bessel_value mismatch, expected %0d actual %0d",
                           $time, want, rsp_ch.bessel_value);
                  errors++;
               end
            end
         end
         if (!hold_done && sent >= 200) begin
            hold_done <= 1;
            hold_left <= 6000;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (sent > 400 && sent < 650) || $urandom_range(0, 99) >= 12;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timeout", $time);
         $display("** bessel_first_kind_simpson_top: FAILED **");
         $finish;
      end
   end

   task automatic write_order(logic [ORDER_W-1:0] n);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      model_order  = n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_args.size() == 0 && !req_ch.valid && expected_values.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      model_order = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: edges of the argument at the reset order
      pending_args.push_back(24'sd0);
      pending_args.push_back(24'sh7FFFFF);
      pending_args.push_back(24'sh800000);
      pending_args.push_back(24'sh800001);
      pending_args.push_back(-24'sd1);
      pending_args.push_back(24'sd1);
      pending_args.push_back(24'sd65536);
      pending_args.push_back(-24'sd65536);
      pending_args.push_back(24'sd157286);
      pending_args.push_back(24'sd5898240);
      pending_args.push_back(-24'sd5898240);
      pending_args.push_back(24'sh555555);
      pending_args.push_back(24'shAAAAAA);
      drain();
      foreach (ORDER_LIST[p]) begin
         write_order(ORDER_LIST[p][ORDER_W-1:0]);
         pending_args.push_back(24'sd0);
         pending_args.push_back(24'sh7FFFFF);
         pending_args.push_back(24'sh800000);
         for (int k = 0; k < PER_PHASE - 3; k++) pending_args.push_back(random_arg());
         drain();
      end
      $display("Covered %0d arguments over %0d orders incl. 0 and 15, with a long result stall.",
               sent, $size(ORDER_LIST));
      if (errors == 0) begin
         $display("** bessel_first_kind_simpson_top: PASSED **");
      end else begin
         $display("** bessel_first_kind_simpson_top: FAILED **");
      end
      $finish;
   end
endmodule
